/* rtl/assert_macros.svh */
// Assertion macros for the basic block partitioner.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked out of reset only.
`define BBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define BBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/bbp_pkg.sv */
// Shared types and constants of the basic block partitioner.
// No dependencies.
`timescale 1ns / 1ps

package bbp_pkg;

  localparam int MAX_LABELS        = 256;
  localparam int MAX_BLOCKS        = 256;
  localparam int PENDING_PER_LABEL = 16;

  localparam int LBL_W   = $clog2(MAX_LABELS);
  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int PIDX_W  = $clog2(PENDING_PER_LABEL);
  localparam int PCNT_W  = $clog2(PENDING_PER_LABEL + 1);
  localparam int PADDR_W = LBL_W + PIDX_W;
  localparam int PEND_DEPTH = MAX_LABELS * PENDING_PER_LABEL;
  localparam int POS_W   = 16;

  typedef enum logic [2:0] {
    OP_PLAIN  = 3'd0,
    OP_BRANCH = 3'd1,
    OP_JUMP   = 3'd2,
    OP_LABEL  = 3'd3,
    OP_RETURN = 3'd4
  } op_class_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CAPTURE,
    ACT_PREP,
    ACT_CLOSE_REC,
    ACT_CLOSE_FT,
    ACT_BR,
    ACT_WALK_EM,
    ACT_LABEL_DONE,
    ACT_RET,
    ACT_TAIL,
    ACT_LAST_REC,
    ACT_LAST_EX,
    ACT_LAST_UPD,
    ACT_FINISH
  } act_e;

  typedef struct packed {
    act_e act;
  } bbp_cmd_t;

  typedef struct packed {
    op_class_e op;
    logic      first;
    logic      last;
    logic      snb;
    logic      pef;
    logic      known;
    logic      walk_done;
    logic      emit_ok;
    logic      stg_valid;
  } bbp_stat_t;

endpackage

/* rtl/bbp_ctrl.sv */
// Sequencer of the basic block partitioner.
// Depends on bbp_pkg; drives commands to bbp_dpath.
`timescale 1ns / 1ps

module bbp_ctrl import bbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  bbp_stat_t stat_i,
  output bbp_cmd_t  cmd_o,
  output logic      idle_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_DISP, S_C1_REC, S_C1_FT, S_BODY, S_BR, S_L_REC, S_L_FT,
    S_WALK, S_WALK_EM, S_L_DONE, S_RET, S_TAIL, S_LAST_REC, S_LAST_EX,
    S_LAST_UPD, S_FIN
  } state_e;

  state_e state_q, state_d;
  act_e   act;

  always_comb begin
    state_d = state_q;
    act     = ACT_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act     = ACT_CAPTURE;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        act     = ACT_PREP;
        state_d = S_DISP;
      end
      S_DISP: begin
        state_d = (stat_i.snb && stat_i.op != OP_LABEL) ? S_C1_REC : S_BODY;
      end
      S_C1_REC: begin
        if (stat_i.emit_ok) begin
          act     = ACT_CLOSE_REC;
          state_d = stat_i.pef ? S_BODY : S_C1_FT;
        end
      end
      S_C1_FT: begin
        if (stat_i.emit_ok) begin
          act     = ACT_CLOSE_FT;
          state_d = S_BODY;
        end
      end
      S_BODY: begin
        case (stat_i.op)
          OP_BRANCH, OP_JUMP: state_d = S_BR;
          OP_LABEL:           state_d = stat_i.first ? S_WALK : S_L_REC;
          OP_RETURN:          state_d = S_RET;
          default:            state_d = S_TAIL;
        endcase
      end
      S_BR: begin
        if (stat_i.emit_ok) begin
          act     = ACT_BR;
          state_d = S_TAIL;
        end
      end
      S_L_REC: begin
        if (stat_i.emit_ok) begin
          act     = ACT_CLOSE_REC;
          state_d = stat_i.pef ? S_WALK : S_L_FT;
        end
      end
      S_L_FT: begin
        if (stat_i.emit_ok) begin
          act     = ACT_CLOSE_FT;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        state_d = stat_i.walk_done ? S_L_DONE : S_WALK_EM;
      end
      S_WALK_EM: begin
        if (stat_i.emit_ok) begin
          act     = ACT_WALK_EM;
          state_d = S_WALK;
        end
      end
      S_L_DONE: begin
        act     = ACT_LABEL_DONE;
        state_d = S_TAIL;
      end
      S_RET: begin
        if (stat_i.emit_ok) begin
          act     = ACT_RET;
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        act     = ACT_TAIL;
        state_d = stat_i.last ? S_LAST_REC : S_FIN;
      end
      S_LAST_REC: begin
        if (stat_i.emit_ok) begin
          act     = ACT_LAST_REC;
          state_d = (stat_i.op == OP_RETURN) ? S_LAST_UPD : S_LAST_EX;
        end
      end
      S_LAST_EX: begin
        if (stat_i.emit_ok) begin
          act     = ACT_LAST_EX;
          state_d = S_LAST_UPD;
        end
      end
      S_LAST_UPD: begin
        act     = ACT_LAST_UPD;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.emit_ok) begin
          act     = ACT_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.act = act;
  assign idle_o    = (state_q == S_IDLE);

endmodule

/* rtl/bbp_dpath.sv */
// Datapath of the basic block partitioner: label tables, pending lists,
// block state, result staging and output register. Depends on bbp_pkg.
`timescale 1ns / 1ps

module bbp_dpath import bbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbp_cmd_t           cmd_i,
  output bbp_stat_t          stat_o,
  input  logic [2:0]         op_class_i,
  input  logic [7:0]         label_id_i,
  input  logic [POS_W-1:0]   quad_index_i,
  input  logic               first_of_function_i,
  input  logic               last_of_function_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               record_kind_o,
  output logic [7:0]         block_index_o,
  output logic [POS_W-1:0]   begin_position_o,
  output logic [POS_W-1:0]   end_position_o,
  output logic [7:0]         target_block_o,
  output logic               target_is_exit_o,
  output logic               overflow_flag_o,
  output logic               last_result_o
);

  typedef struct packed {
    logic             kind;
    logic [BLK_W-1:0] blk;
    logic [POS_W-1:0] beg;
    logic [POS_W-1:0] fin;
    logic [BLK_W-1:0] tgt;
    logic             ex;
  } rec_t;

  // per-label entry: label seen, pending count
  typedef struct packed {
    logic              known;
    logic [PCNT_W-1:0] cnt;
  } lbl_ent_t;

  // transaction item
  op_class_e        op_q;
  logic [LBL_W-1:0] lbl_q;
  logic [POS_W-1:0] pos_q;
  logic             first_q, last_q;

  // block state
  logic [BLK_W-1:0] bc_q, closed_q;
  logic [POS_W-1:0] start_q;
  logic             snb_q, pef_q, ft_q, ovf_q;
  logic [PCNT_W-1:0] walk_i_q;

  // an entry whose valid bit is clear reads as zero
  logic              lbl_vld_q       [MAX_LABELS];
  lbl_ent_t          lbl_tab_mem     [MAX_LABELS];
  logic [BLK_W-1:0]  label_block_mem [MAX_LABELS];
  logic [BLK_W-1:0]  pend_src_mem    [PEND_DEPTH];
  logic [BLK_W-1:0]  lb_rd_q, ps_rd_q;
  lbl_ent_t          tab_rd_q, ent_q, ent_pre;

  rec_t stg_q, out_q, rec;
  logic stg_valid_q, out_valid_q, out_last_q, out_ovf_q, out_valid_d;
  logic emit, out_free, emit_ok, out_load;

  op_class_e         op_in;
  logic [BLK_W-1:0]  nxt;
  logic              known, cnt_full;
  logic [PCNT_W-1:0] cnt;
  logic [PADDR_W-1:0] wr_addr, rd_addr;

  always_comb begin
    case (op_class_i)
      3'd1:    op_in = OP_BRANCH;
      3'd2:    op_in = OP_JUMP;
      3'd3:    op_in = OP_LABEL;
      3'd4:    op_in = OP_RETURN;
      default: op_in = OP_PLAIN;
    endcase
  end

  assign ent_pre  = (first_q || !lbl_vld_q[lbl_q]) ? '0 : tab_rd_q;
  assign nxt      = (bc_q == BLK_W'(MAX_BLOCKS - 1)) ? bc_q : bc_q + 1'b1;
  assign known    = ent_q.known;
  assign cnt      = ent_q.cnt;
  assign cnt_full = (cnt >= PCNT_W'(PENDING_PER_LABEL));
  assign wr_addr  = {lbl_q, cnt[PIDX_W-1:0]};
  assign rd_addr  = {lbl_q, walk_i_q[PIDX_W-1:0]};

  // Overflow for the whole item, worked out before any result goes out.
  logic             first_e, snb_e, known_e, cnt_full_e, ob, opf;
  logic [BLK_W-1:0] bc_e;
  logic [1:0]       ncalls;
  always_comb begin
    first_e    = first_q;
    bc_e       = first_q ? '0 : bc_q;
    snb_e      = snb_q & ~first_q;
    known_e    = ent_pre.known;
    cnt_full_e = (ent_pre.cnt >= PCNT_W'(PENDING_PER_LABEL));
    ncalls     = 2'(snb_e && op_q != OP_LABEL) + 2'(op_q == OP_LABEL && !first_e)
               + 2'(last_q);
    ob  = (ncalls != 2'd0 && bc_e == BLK_W'(MAX_BLOCKS - 1)) ||
          (ncalls >= 2'd2 && bc_e == BLK_W'(MAX_BLOCKS - 2));
    opf = (op_q == OP_BRANCH || op_q == OP_JUMP) && !known_e && cnt_full_e;
  end

  always_comb begin
    rec  = '0;
    emit = 1'b0;
    case (cmd_i.act)
      ACT_CLOSE_REC: begin
        emit     = 1'b1;
        rec.blk  = bc_q;
        rec.beg  = start_q;
        rec.fin  = pos_q - 1'b1;
      end
      ACT_CLOSE_FT: begin
        emit     = 1'b1;
        rec.kind = 1'b1;
        rec.blk  = closed_q;
        rec.tgt  = bc_q;
      end
      ACT_BR: begin
        emit     = known;
        rec.kind = 1'b1;
        rec.blk  = bc_q;
        rec.tgt  = lb_rd_q;
      end
      ACT_WALK_EM: begin
        // skip the edge the fall-through already gave
        emit     = !(!first_q && ft_q && ps_rd_q == closed_q);
        rec.kind = 1'b1;
        rec.blk  = ps_rd_q;
        rec.tgt  = bc_q;
      end
      ACT_RET, ACT_LAST_EX: begin
        emit     = 1'b1;
        rec.kind = 1'b1;
        rec.blk  = bc_q;
        rec.ex   = 1'b1;
      end
      ACT_LAST_REC: begin
        emit     = 1'b1;
        rec.blk  = bc_q;
        rec.beg  = start_q;
        rec.fin  = pos_q;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_ok  = !stg_valid_q || out_free;
  assign out_load = stg_valid_q && ((emit && out_free) || cmd_i.act == ACT_FINISH);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_CAPTURE) begin
      lb_rd_q  <= label_block_mem[label_id_i[LBL_W-1:0]];
      tab_rd_q <= lbl_tab_mem[label_id_i[LBL_W-1:0]];
    end
    if (cmd_i.act == ACT_LABEL_DONE) begin
      label_block_mem[lbl_q] <= bc_q;
    end
    if (cmd_i.act == ACT_TAIL) begin
      lbl_tab_mem[lbl_q] <= ent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ps_rd_q <= pend_src_mem[rd_addr];
    if (cmd_i.act == ACT_BR && !known && !cnt_full) begin
      pend_src_mem[wr_addr] <= bc_q;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_CAPTURE) begin
      op_q    <= op_in;
      lbl_q   <= label_id_i[LBL_W-1:0];
      pos_q   <= quad_index_i;
      first_q <= first_of_function_i;
      last_q  <= last_of_function_i;
    end
    if (cmd_i.act == ACT_PREP) begin
      ent_q <= ent_pre;
    end else if (cmd_i.act == ACT_BR && !known && !cnt_full) begin
      ent_q.cnt <= cnt + 1'b1;
    end else if (cmd_i.act == ACT_LABEL_DONE) begin
      ent_q.known <= 1'b1;
    end
    if (cmd_i.act == ACT_CLOSE_REC) begin
      closed_q <= bc_q;
    end
    if (emit) begin
      stg_q <= rec;
    end
    if (out_load) begin
      out_q      <= stg_q;
      out_ovf_q  <= ovf_q;
      out_last_q <= (cmd_i.act == ACT_FINISH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q        <= '0;
      start_q     <= '0;
      snb_q       <= 1'b0;
      pef_q       <= 1'b0;
      ft_q        <= 1'b0;
      ovf_q       <= 1'b0;
      walk_i_q    <= '0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_LABELS; i++) begin
        lbl_vld_q[i] <= 1'b0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      case (cmd_i.act)
        ACT_PREP: begin
          ovf_q    <= (ovf_q & ~first_q) | ob | opf;
          walk_i_q <= '0;
          if (first_q) begin
            bc_q    <= '0;
            start_q <= pos_q;
            snb_q   <= 1'b0;
            pef_q   <= 1'b0;
            ft_q    <= 1'b0;
            for (int i = 0; i < MAX_LABELS; i++) begin
              lbl_vld_q[i] <= 1'b0;
            end
          end
        end
        ACT_CLOSE_REC: begin
          bc_q    <= nxt;
          start_q <= pos_q;
          ft_q    <= ~pef_q;
        end
        ACT_WALK_EM: walk_i_q <= walk_i_q + 1'b1;
        ACT_LABEL_DONE: begin
          start_q <= pos_q;
        end
        ACT_TAIL: begin
          snb_q            <= (op_q == OP_BRANCH || op_q == OP_JUMP || op_q == OP_RETURN);
          pef_q            <= (op_q == OP_JUMP || op_q == OP_RETURN);
          lbl_vld_q[lbl_q] <= 1'b1;
        end
        ACT_LAST_UPD: begin
          bc_q    <= nxt;
          start_q <= pos_q + 1'b1;
          snb_q   <= 1'b0;
          pef_q   <= 1'b0;
        end
        default: ;
      endcase
      if (emit) begin
        stg_valid_q <= 1'b1;
      end else if (cmd_i.act == ACT_FINISH && stg_valid_q) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.op        = op_q;
    stat_o.first     = first_q;
    stat_o.last      = last_q;
    stat_o.snb       = snb_q;
    stat_o.pef       = pef_q;
    stat_o.known     = known;
    stat_o.walk_done = (walk_i_q >= cnt);
    stat_o.emit_ok   = emit_ok;
    stat_o.stg_valid = stg_valid_q;
  end

  assign out_valid_o      = out_valid_q;
  assign record_kind_o    = out_q.kind;
  assign block_index_o    = 8'(out_q.blk);
  assign begin_position_o = out_q.beg;
  assign end_position_o   = out_q.fin;
  assign target_block_o   = 8'(out_q.tgt);
  assign target_is_exit_o = out_q.ex;
  assign overflow_flag_o  = out_ovf_q;
  assign last_result_o    = out_last_q;

endmodule

/* rtl/basic_block_partitioner.sv */
// Channel | dir | handshake           | payload
// in      | in  | in_valid_i/in_stall_o | op_class, label_id, quad_index, first/last
// out     | out | out_valid_o/out_stall_i | record fields, overflow, last_result
//
// One instruction is worked on at a time by the sequencer in bbp_ctrl; the next
// transaction is taken only once the sequencer is back in S_IDLE. A branch, jump or
// return adds an edge step; closing a block adds a record step, plus a step for its
// fall-through edge; a label walks its pending entries (one pending-source read each);
// last_of_function adds a closing record and, unless after a return, an exit edge.
// Reset and function start clear the label valid bits at once.
// A stalled output holds the sequencer at its next result.
// Top level of the basic block partitioner; depends on bbp_pkg, bbp_ctrl,
// bbp_dpath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module basic_block_partitioner import bbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       op_class_i,
  input  logic [7:0]       label_id_i,
  input  logic [POS_W-1:0] quad_index_i,
  input  logic             first_of_function_i,
  input  logic             last_of_function_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             record_kind_o,
  output logic [7:0]       block_index_o,
  output logic [POS_W-1:0] begin_position_o,
  output logic [POS_W-1:0] end_position_o,
  output logic [7:0]       target_block_o,
  output logic             target_is_exit_o,
  output logic             overflow_flag_o,
  output logic             last_result_o
);

  bbp_cmd_t  cmd;
  bbp_stat_t stat;
  logic      idle;

  bbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  bbp_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .op_class_i          (op_class_i),
    .label_id_i          (label_id_i),
    .quad_index_i        (quad_index_i),
    .first_of_function_i (first_of_function_i),
    .last_of_function_i  (last_of_function_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .record_kind_o       (record_kind_o),
    .block_index_o       (block_index_o),
    .begin_position_o    (begin_position_o),
    .end_position_o      (end_position_o),
    .target_block_o      (target_block_o),
    .target_is_exit_o    (target_is_exit_o),
    .overflow_flag_o     (overflow_flag_o),
    .last_result_o       (last_result_o)
  );

  assign in_stall_o = !idle;

  `BBP_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid in reset")
  `BBP_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy")
  `BBP_ASSERT(a_idle_stage_empty, idle |-> !stat.stg_valid, "staged result left behind")

endmodule
